// ===== src/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store: operation and
// status codes, fixed field widths and the result metadata bundle.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Default sizing handed to the top-level parameters
  localparam int DEPTH_DEF = 1024;
  localparam int WIDTH_DEF = 32;

  // Fixed field widths of the request and response payloads
  localparam int OP_W   = 3;
  localparam int POS_W  = 10;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // Response fields that do not depend on the element width
  typedef struct packed {
    status_e          status;
    logic [LEN_W-1:0] list_length;
    logic             empty_flag;
    logic [LEN_W-1:0] logical_capacity;
  } res_meta_t;

endpackage

// ===== src/ils_if.sv =====
// ----------------------------------------------------------------------------
// ils_req_if / ils_rsp_if
// Valid/ready channels of the indexed list store: one request channel and
// one response channel.
// ----------------------------------------------------------------------------
interface ils_req_if #(
  parameter int WIDTH = ils_pkg::WIDTH_DEF
);
  logic                      valid;
  logic                      ready;
  logic [ils_pkg::OP_W-1:0]  operation;
  logic [ils_pkg::POS_W-1:0] position;
  logic [WIDTH-1:0]          data_in;

  modport source (output valid, output operation, output position, output data_in,
                  input ready);
  modport sink   (input valid, input operation, input position, input data_in,
                  output ready);
endinterface

interface ils_rsp_if #(
  parameter int WIDTH = ils_pkg::WIDTH_DEF
);
  logic                       valid;
  logic                       ready;
  logic [ils_pkg::STAT_W-1:0] status;
  logic [WIDTH-1:0]           data_out;
  logic [ils_pkg::LEN_W-1:0]  list_length;
  logic                       empty_flag;
  logic [ils_pkg::LEN_W-1:0]  logical_capacity;

  modport source (output valid, output status, output data_out, output list_length,
                  output empty_flag, output logical_capacity, input ready);
  modport sink   (input valid, input status, input data_out, input list_length,
                  input empty_flag, input logical_capacity, output ready);
endinterface

// ===== src/ils_mem.sv =====
// ----------------------------------------------------------------------------
// ils_mem
// Element store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ils_mem #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF,
  parameter int WIDTH = ils_pkg::WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ils_seq.sv =====
// ----------------------------------------------------------------------------
// ils_seq
// Operation sequencer: holds length and capacity, runs the capacity
// doubling, and walks the element store for zero fill and shifts.
// ----------------------------------------------------------------------------
module ils_seq #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF,
  parameter int WIDTH = ils_pkg::WIDTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // request side
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ils_pkg::OP_W-1:0]  op_i,
  input  logic [ils_pkg::POS_W-1:0] pos_i,
  input  logic [WIDTH-1:0]          din_i,
  // result side
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output ils_pkg::res_meta_t        res_meta_o,
  output logic [WIDTH-1:0]          res_data_o,
  // element store
  output logic                      mem_we_o,
  output logic [AW-1:0]             mem_waddr_o,
  output logic [WIDTH-1:0]          mem_wdata_o,
  output logic                      mem_re_o,
  output logic [AW-1:0]             mem_raddr_o,
  input  logic [WIDTH-1:0]          mem_rdata_i
);

  // Count width holds DEPTH itself; XW covers count, position and 2*count
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CAP  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_SHUP = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;
  localparam logic [2:0] S_RDP  = 3'd5;
  localparam logic [2:0] S_SHDN = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]              state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           cap_q, cap_d;
  logic                    pv_q, pv_d;
  logic [ils_pkg::OP_W-1:0] op_q, op_d;
  logic [XW-1:0]           p_q, p_d;
  logic [WIDTH-1:0]        din_q, din_d;
  logic [XW-1:0]           c_q, c_d;
  logic [XW-1:0]           idx_q, idx_d;
  logic [AW-1:0]           wa_q, wa_d;
  ils_pkg::status_e        stat_q, stat_d;
  logic [WIDTH-1:0]        rd_q, rd_d;

  logic [XW-1:0] cnt_x, cap_x, depth_x, in_p_x, ins_p_x, base_x, c0_x;
  logic [XW-1:0] idx_m1, cur_base_x;
  logic          in_range_fail, shup_issue, shdn_issue;

  // Widened views of the state for compares
  assign cnt_x   = XW'(cnt_q);
  assign cap_x   = XW'(cap_q);
  assign depth_x = XW'(DEPTH);
  assign in_p_x  = XW'(pos_i);
  assign ins_p_x = (op_i == ils_pkg::OP_APPEND) ? cnt_x : in_p_x;
  assign base_x  = (ins_p_x > cnt_x) ? ins_p_x : cnt_x;
  assign cur_base_x = (p_q > cnt_x) ? p_q : cnt_x;
  assign idx_m1  = idx_q - XW'(1);
  assign in_range_fail = (in_p_x >= cnt_x);

  // Starting capacity before doubling
  assign c0_x = (cnt_q != cap_q) ? cap_x :
                (cap_q == '0)    ? XW'(1) : (cnt_x << 1);

  // Shift walks: one read issued per cycle, written back in the next cycle
  assign shup_issue = (idx_q > p_q);
  assign shdn_issue = (idx_q < cnt_x);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  assign res_meta_o.status           = stat_q;
  assign res_meta_o.list_length      = cnt_x[ils_pkg::LEN_W-1:0];
  assign res_meta_o.empty_flag       = (cnt_q == '0);
  assign res_meta_o.logical_capacity = cap_x[ils_pkg::LEN_W-1:0];
  assign res_data_o                  = rd_q;

  // Next-state and store access
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cap_d   = cap_q;
    pv_d    = pv_q;
    op_d    = op_q;
    p_d     = p_q;
    din_d   = din_q;
    c_d     = c_q;
    idx_d   = idx_q;
    wa_d    = wa_q;
    stat_d  = stat_q;
    rd_d    = rd_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          din_d  = din_i;
          rd_d   = '0;
          stat_d = ils_pkg::STAT_OK;
          p_d    = in_p_x;
          pv_d   = 1'b0;
          case (op_i)
            ils_pkg::OP_APPEND, ils_pkg::OP_INSERT: begin
              p_d = ins_p_x;
              if ((base_x + XW'(1)) > depth_x) begin
                stat_d  = ils_pkg::STAT_FULL;
                state_d = S_DONE;
              end else begin
                c_d     = c0_x;
                state_d = S_CAP;
              end
            end
            ils_pkg::OP_REMOVE, ils_pkg::OP_GET: begin
              if (in_range_fail) begin
                stat_d  = ils_pkg::STAT_RANGE;
                state_d = S_DONE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = in_p_x[AW-1:0];
                state_d     = S_RDP;
              end
            end
            ils_pkg::OP_SET: begin
              if (in_range_fail) begin
                stat_d = ils_pkg::STAT_RANGE;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = in_p_x[AW-1:0];
                mem_wdata_o = din_i;
              end
              state_d = S_DONE;
            end
            ils_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              cap_d   = '0;
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      // Double until the capacity covers the index, then clamp
      S_CAP: begin
        if ((c_q <= p_q) && (c_q < depth_x) && (c_q != '0)) begin
          c_d = c_q << 1;
        end else begin
          cap_d = (c_q > depth_x) ? CW'(depth_x) : CW'(c_q);
          idx_d = cnt_x;
          if (p_q > cnt_x) begin
            state_d = S_FILL;
          end else if (cnt_x > p_q) begin
            state_d = S_SHUP;
          end else begin
            state_d = S_PUT;
          end
        end
      end

      // Zero the gap between the old end and the insert index
      S_FILL: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_q[AW-1:0];
        idx_d       = idx_q + XW'(1);
        if ((idx_q + XW'(1)) == p_q) begin
          state_d = S_PUT;
        end
      end

      // Move entries up: read idx-1, write it to idx next cycle
      S_SHUP: begin
        if (shup_issue) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_m1[AW-1:0];
          idx_d       = idx_m1;
        end
        if (pv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wa_q;
          mem_wdata_o = mem_rdata_i;
        end
        pv_d = shup_issue;
        wa_d = idx_q[AW-1:0];
        if (!shup_issue && !pv_q) begin
          state_d = S_PUT;
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = p_q[AW-1:0];
        mem_wdata_o = din_q;
        cnt_d       = CW'(cur_base_x + XW'(1));
        state_d     = S_DONE;
      end

      // Read data of the indexed entry is valid here
      S_RDP: begin
        rd_d = mem_rdata_i;
        if (op_q == ils_pkg::OP_REMOVE) begin
          idx_d   = p_q + XW'(1);
          pv_d    = 1'b0;
          state_d = S_SHDN;
        end else begin
          state_d = S_DONE;
        end
      end

      // Move entries down: read idx, write it to idx-1 next cycle
      S_SHDN: begin
        if (shdn_issue) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q[AW-1:0];
          idx_d       = idx_q + XW'(1);
        end
        if (pv_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = wa_q;
          mem_wdata_o = mem_rdata_i;
        end
        pv_d = shdn_issue;
        wa_d = idx_m1[AW-1:0];
        if (!shdn_issue && !pv_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cap_q   <= '0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      pv_q    <= pv_d;
    end
  end

  // Working registers of the current request
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    p_q    <= p_d;
    din_q  <= din_d;
    c_q    <= c_d;
    idx_q  <= idx_d;
    wa_q   <= wa_d;
    stat_q <= stat_d;
    rd_q   <= rd_d;
  end

endmodule

// ===== src/ils_outreg.sv =====
// ----------------------------------------------------------------------------
// ils_outreg
// Response register: holds one finished result so that the sequencer can
// take the next request while the result waits to be taken.
// ----------------------------------------------------------------------------
module ils_outreg #(
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  ils_pkg::res_meta_t meta_i,
  input  logic [WIDTH-1:0]   data_i,
  ils_rsp_if.source          rsp_o
);

  logic               full_q;
  ils_pkg::res_meta_t meta_q;
  logic [WIDTH-1:0]   data_q;
  logic               push;

  assign push_ready_o = !full_q || rsp_o.ready;
  assign push         = push_valid_i && push_ready_o;

  // Occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (push) begin
      full_q <= 1'b1;
    end else if (rsp_o.ready) begin
      full_q <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      meta_q <= meta_i;
      data_q <= data_i;
    end
  end

  assign rsp_o.valid            = full_q;
  assign rsp_o.status           = meta_q.status;
  assign rsp_o.data_out         = data_q;
  assign rsp_o.list_length      = meta_q.list_length;
  assign rsp_o.empty_flag       = meta_q.empty_flag;
  assign rsp_o.logical_capacity = meta_q.logical_capacity;

endmodule

// ===== src/indexed_list_store.sv =====
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of up to DEPTH elements kept in a single-port-pair RAM, with
// append, insert, remove, get, set and clear requests.
// ----------------------------------------------------------------------------
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-------------------------------------------
//  req_i   | in  | valid/ready | operation, position, data_in
//  rsp_o   | out | valid/ready | status, data_out, list_length, empty_flag,
//          |     |             | logical_capacity
//
//  Get reads the entry from the RAM; set, clear and failed requests need no read.
//  Insert/append: capacity doublings (up to log2 DEPTH), then zero fill of the gap
//  or a shift of the tail up, then the write of the new entry; remove: read of the
//  entry, then a shift down of the entries behind it. Each shift makes one RAM
//  access per element per port.
//  Reset clears length and capacity at once; the RAM contents are not cleared.
//  One request is worked at a time; a finished result parks in the response
//  register, so a stalled response only holds back the finish of the next one.
// ----------------------------------------------------------------------------
module indexed_list_store #(
  parameter int DEPTH = ils_pkg::DEPTH_DEF,
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ils_req_if.sink   req_i,
  ils_rsp_if.source rsp_o
);

  localparam int AW = $clog2(DEPTH);

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [WIDTH-1:0]   mem_wdata, mem_rdata;
  logic               res_valid, res_ready;
  ils_pkg::res_meta_t res_meta;
  logic [WIDTH-1:0]   res_data;

  ils_seq #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .op_i        (req_i.operation),
    .pos_i       (req_i.position),
    .din_i       (req_i.data_in),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_meta_o  (res_meta),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ils_mem #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  ils_outreg #(.WIDTH(WIDTH)) u_outreg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (res_valid),
    .push_ready_o (res_ready),
    .meta_i       (res_meta),
    .data_i       (res_data),
    .rsp_o        (rsp_o)
  );

endmodule

// ===== src/ils_checker.sv =====
// ----------------------------------------------------------------------------
// ils_checker
// Port-level checks of the indexed list store: result consistency, request
// to response accounting and response hold under stall.
// ----------------------------------------------------------------------------
module ils_checker #(
  parameter int WIDTH = ils_pkg::WIDTH_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [ils_pkg::STAT_W-1:0] status_i,
  input logic [WIDTH-1:0]           data_out_i,
  input logic [ils_pkg::LEN_W-1:0]  list_length_i,
  input logic                       empty_flag_i
);

  logic       req_fire, rsp_fire;
  logic [1:0] pend_q;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // Requests taken but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (req_fire && !rsp_fire) begin
      pend_q <= pend_q + 2'd1;
    end else if (rsp_fire && !req_fire) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  // At most one request in work and one result parked; no result unasked
  a_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q != 2'd3) && (!rsp_valid_i || (pend_q != 2'd0)))
    else $error("response count out of step with requests");

  // Empty flag follows the reported length
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (empty_flag_i == (list_length_i == '0)))
    else $error("empty flag disagrees with length");

  // Failed requests return no data
  a_fail_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (status_i != ils_pkg::STAT_OK)) |-> (data_out_i == '0))
    else $error("failed request returned data");

  // A stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(status_i) && $stable(data_out_i) && $stable(list_length_i)))
    else $error("stalled response changed");

endmodule

bind indexed_list_store ils_checker #(.WIDTH(WIDTH)) u_ils_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .data_out_i    (rsp_o.data_out),
  .list_length_i (rsp_o.list_length),
  .empty_flag_i  (rsp_o.empty_flag)
);
